// ===== sv/cfc_pkg.sv =====
// Shared types and constants for the control frame checker.
`default_nettype none
package cfc_pkg;

   localparam int DataBytes  = 16;
   localparam int FrameBytes = DataBytes + 5;
   localparam int DataStart  = 3;
   localparam int PosWidth   = $clog2(FrameBytes + 1);
   localparam int IdxWidth   = $clog2(DataBytes);
   localparam int Words      = DataBytes / 4;
   localparam int AddrWidth  = 4;

   localparam logic [PosWidth-1:0] PosHead  = PosWidth'(0);
   localparam logic [PosWidth-1:0] PosFunc  = PosWidth'(1);
   localparam logic [PosWidth-1:0] PosLen   = PosWidth'(2);
   localparam logic [PosWidth-1:0] PosData  = PosWidth'(DataStart);
   localparam logic [PosWidth-1:0] PosCheck = PosWidth'(DataStart + DataBytes);
   localparam logic [PosWidth-1:0] PosFull  = PosWidth'(FrameBytes);
   localparam logic [7:0]          LenValue = 8'(DataBytes);

   typedef enum logic [1:0] {
      REG_HEAD    = 2'd0,
      REG_TAIL    = 2'd1,
      REG_CONTROL = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ERR_OK       = 3'd0,
      ERR_SHORT    = 3'd1,
      ERR_HEAD     = 3'd2,
      ERR_TAIL     = 3'd3,
      ERR_FUNCTION = 3'd4,
      ERR_LENGTH   = 3'd5,
      ERR_CHECKSUM = 3'd6
   } err_type;

   typedef struct packed {
      logic [7:0] head_byte;
      logic [7:0] tail_byte;
      logic [7:0] control_code;
   } cfg_type;

   typedef struct packed {
      logic                  frame_ok;
      err_type               error_code;
      logic [Words-1:0][31:0] words;
   } result_type;

endpackage
`default_nettype wire

// ===== sv/cfc_csr.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none
module cfc_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [cfc_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output cfc_pkg::cfg_type                   cfg
);

   cfc_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]       index;
   logic             write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[3:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            cfc_pkg::REG_HEAD:    cfg_in.head_byte    = csr_pwdata[7:0];
            cfc_pkg::REG_TAIL:    cfg_in.tail_byte    = csr_pwdata[7:0];
            cfc_pkg::REG_CONTROL: cfg_in.control_code = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         cfc_pkg::REG_HEAD:    csr_prdata = {24'd0, cfg_ff.head_byte};
         cfc_pkg::REG_TAIL:    csr_prdata = {24'd0, cfg_ff.tail_byte};
         cfc_pkg::REG_CONTROL: csr_prdata = {24'd0, cfg_ff.control_code};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== sv/cfc_deframer.sv =====
// Per-byte frame state, payload capture and the verdict at buffer end.
`default_nettype none
module cfc_deframer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire logic [7:0]          rx_byte,
   input  wire logic                buffer_end,
   input  cfc_pkg::cfg_type         cfg,
   output cfc_pkg::result_type      result
);

   logic [cfc_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic [7:0]                   sum_ff, sum_in;
   logic [2:0]                   flags_ff, flags_in;
   logic [7:0]                   check_ff, check_in;
   logic [7:0]                   tail_ff, tail_in;
   logic [7:0]                   payload_ff [cfc_pkg::DataBytes];
   logic [7:0]                   payload_now [cfc_pkg::DataBytes];
   logic                         keep;
   logic                         is_data;
   logic [cfc_pkg::PosWidth-1:0] data_off;
   logic [cfc_pkg::IdxWidth-1:0] data_idx;
   cfc_pkg::err_type             err;

   assign keep     = pos_ff < cfc_pkg::PosFull;
   assign is_data  = keep && pos_ff >= cfc_pkg::PosData && pos_ff < cfc_pkg::PosCheck;
   assign data_off = pos_ff - cfc_pkg::PosData;
   assign data_idx = data_off[cfc_pkg::IdxWidth-1:0];

   // state as it stands once this byte is taken in
   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      flags_in = flags_ff;
      check_in = check_ff;
      tail_in  = tail_ff;
      if (keep) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff == cfc_pkg::PosHead) begin
            if (rx_byte != cfg.head_byte) flags_in[0] = 1'b1;
            sum_in = sum_ff + rx_byte;
         end else if (pos_ff == cfc_pkg::PosFunc) begin
            if (rx_byte != cfg.control_code) flags_in[1] = 1'b1;
            sum_in = sum_ff + rx_byte;
         end else if (pos_ff == cfc_pkg::PosLen) begin
            if (rx_byte != cfc_pkg::LenValue) flags_in[2] = 1'b1;
         end else if (is_data) begin
            sum_in = sum_ff + rx_byte;
         end else if (pos_ff == cfc_pkg::PosCheck) begin
            check_in = rx_byte;
         end else begin
            tail_in = rx_byte;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < cfc_pkg::DataBytes; i++) begin
         payload_now[i] = payload_ff[i];
      end
      if (is_data) payload_now[data_idx] = rx_byte;
   end

   // first fault wins
   always_comb begin
      if (pos_in != cfc_pkg::PosFull)        err = cfc_pkg::ERR_SHORT;
      else if (flags_in[0])                  err = cfc_pkg::ERR_HEAD;
      else if (tail_in != cfg.tail_byte)     err = cfc_pkg::ERR_TAIL;
      else if (flags_in[1])                  err = cfc_pkg::ERR_FUNCTION;
      else if (flags_in[2])                  err = cfc_pkg::ERR_LENGTH;
      else if (check_in != ~sum_in)          err = cfc_pkg::ERR_CHECKSUM;
      else                                   err = cfc_pkg::ERR_OK;
   end

   always_comb begin
      result.frame_ok   = (err == cfc_pkg::ERR_OK);
      result.error_code = err;
      for (int k = 0; k < cfc_pkg::Words; k++) begin
         if (err == cfc_pkg::ERR_OK) begin
            result.words[k] = {payload_now[4*k+3], payload_now[4*k+2],
                               payload_now[4*k+1], payload_now[4*k]};
         end else begin
            result.words[k] = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         flags_ff <= '0;
         check_ff <= '0;
         tail_ff  <= '0;
      end else if (step_en) begin
         if (buffer_end) begin
            pos_ff   <= '0;
            sum_ff   <= '0;
            flags_ff <= '0;
            check_ff <= '0;
            tail_ff  <= '0;
         end else begin
            pos_ff   <= pos_in;
            sum_ff   <= sum_in;
            flags_ff <= flags_in;
            check_ff <= check_in;
            tail_ff  <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && is_data) begin
         payload_ff[data_idx] <= rx_byte;
      end
   end

endmodule
`default_nettype wire

// ===== sv/control_frame_checker.sv =====
// Control frame checker: byte-stream deframer with inverted-sum check.
//
// Bytes of a received buffer enter on the req_ channel, one request per byte;
// req_tlast marks the last byte of the buffer. Only the first 21 bytes of a
// buffer count (head, function, length, 16 data bytes, check, tail). For each
// buffer the block sends one verdict on the rsp_ channel: frame_ok and the
// error code in rsp_tuser, and on success the four little-endian data words
// in rsp_tdata (zero on error). Bytes without req_tlast produce nothing.
// Expected head, tail and function code sit in registers on the csr_ port.
// Throughput: one byte per cycle while no final byte waits; each byte passes
// an input register and a compare and 8-bit add, and the verdict of a buffer is
// registered in the result register. The result register holds a verdict until
// rsp_tready; meanwhile non-final bytes keep flowing, and a final byte waits
// in the input register until the result register is free.
// Reset clears registers, the frame state and both valid flags.
`default_nettype none
module control_frame_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] rx_byte
   input  wire logic                          req_tlast,   // buffer_end
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [31:0] right_back_bits, [63:32] right_front_bits,
   // [95:64] left_back_bits, [127:96] left_front_bits
   output logic [127:0]                       rsp_tdata,
   output logic [3:0]                         rsp_tuser,   // [0] frame_ok, [3:1] error_code
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [cfc_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   cfc_pkg::cfg_type    cfg;
   cfc_pkg::result_type result;
   cfc_pkg::result_type out_ff;
   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic                out_valid_ff;
   logic                out_free;
   logic                step_en;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step_en;

   cfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cfc_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .rx_byte    (in_byte_ff),
      .buffer_end (in_last_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.words;
   assign rsp_tuser  = {out_ff.error_code, out_ff.frame_ok};

endmodule
`default_nettype wire

// ===== sv/cfc_checker.sv =====
// Port-level checks for the control frame checker, bound to the top level.
`default_nettype none
module cfc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata,
   input wire logic [3:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("verdict changed while stalled");

   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[3:1] == cfc_pkg::ERR_OK)
      else $error("passed frame carries an error code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[3:1] != cfc_pkg::ERR_OK && rsp_tdata == '0)
      else $error("failed frame without code or with data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("verdict pending after reset");

endmodule

bind control_frame_checker cfc_checker u_cfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the control frame checker: directed and random byte streams.
`timescale 1ns / 1ps
module tb_top;

   localparam int CycleLimit  = 200000;
   localparam int RandomBytes = 830;

   typedef struct packed {
      logic                            ok;
      cfc_pkg::err_type                err;
      logic [cfc_pkg::Words-1:0][31:0] words;
   } verdict_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   wire                           req_tready;
   logic [7:0]                    req_tdata   = 8'h00;
   logic                          req_tlast   = 1'b0;
   wire                           rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   wire  [127:0]                  rsp_tdata;
   wire  [3:0]                    rsp_tuser;
   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [cfc_pkg::AddrWidth-1:0] csr_paddr   = '0;
   logic [31:0]                   csr_pwdata  = 32'h0;
   wire  [31:0]                   csr_prdata;
   wire                           csr_pready;

   // own copy of the registers and the frame state
   bit [7:0]    head_cfg, tail_cfg, ctrl_cfg;
   int unsigned frame_pos;
   bit [7:0]    frame_sum;
   bit [2:0]    hdr_faults;
   bit [7:0]    check_seen, tail_seen;
   bit [7:0]    payload [cfc_pkg::DataBytes];

   verdict_type verdicts_due [$];
   int          mismatches = 0;
   int          cycles     = 0;
   int          bytes_sent = 0;
   int          stall_left = 0;
   bit          idle_on    = 1'b1;
   logic        rsp_hold   = 1'b0;

   control_frame_checker u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("control_frame_checker verification failed");
         $finish;
      end
   end

   // Work out the verdict, if any, that one accepted byte causes.
   task automatic predict_verdict(input bit [7:0] value, input bit last);
      verdict_type      v;
      cfc_pkg::err_type e;
      bit [7:0]         inv;
      if (frame_pos < cfc_pkg::FrameBytes) begin
         if (frame_pos == 0) begin
            if (value != head_cfg) hdr_faults[0] = 1'b1;
            frame_sum += value;
         end else if (frame_pos == 1) begin
            if (value != ctrl_cfg) hdr_faults[1] = 1'b1;
            frame_sum += value;
         end else if (frame_pos == 2) begin
            if (value != cfc_pkg::LenValue) hdr_faults[2] = 1'b1;
         end else if (frame_pos < cfc_pkg::DataStart + cfc_pkg::DataBytes) begin
            payload[frame_pos - cfc_pkg::DataStart] = value;
            frame_sum += value;
         end else if (frame_pos == cfc_pkg::DataStart + cfc_pkg::DataBytes) begin
            check_seen = value;
         end else begin
            tail_seen = value;
         end
         frame_pos++;
      end
      if (last) begin
         inv = ~frame_sum;
         if (frame_pos != cfc_pkg::FrameBytes) e = cfc_pkg::ERR_SHORT;
         else if (hdr_faults[0]) e = cfc_pkg::ERR_HEAD;
         else if (tail_seen != tail_cfg) e = cfc_pkg::ERR_TAIL;
         else if (hdr_faults[1]) e = cfc_pkg::ERR_FUNCTION;
         else if (hdr_faults[2]) e = cfc_pkg::ERR_LENGTH;
         else if (check_seen != inv) e = cfc_pkg::ERR_CHECKSUM;
         else e = cfc_pkg::ERR_OK;
         v.ok  = (e == cfc_pkg::ERR_OK);
         v.err = e;
         v.words = '0;
         if (v.ok) begin
            v.words[0] = {payload[3], payload[2], payload[1], payload[0]};
            v.words[1] = {payload[7], payload[6], payload[5], payload[4]};
            v.words[2] = {payload[11], payload[10], payload[9], payload[8]};
            v.words[3] = {payload[15], payload[14], payload[13], payload[12]};
         end
         verdicts_due.push_back(v);
         frame_pos  = 0;
         frame_sum  = 8'h00;
         hdr_faults = 3'b000;
         check_seen = 8'h00;
         tail_seen  = 8'h00;
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Check each verdict taken and drive the receiver's stalls.
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               $error("verdict with none pending: tuser %0h tdata %0h", rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = verdicts_due.pop_front();
               check_field("frame_ok", 32'(want.ok), 32'(rsp_tuser[0]));
               check_field("error_code", 32'(want.err), 32'(rsp_tuser[3:1]));
               check_field("right_back_bits", want.words[0], rsp_tdata[31:0]);
               check_field("right_front_bits", want.words[1], rsp_tdata[63:32]);
               check_field("left_back_bits", want.words[2], rsp_tdata[95:64]);
               check_field("left_front_bits", want.words[3], rsp_tdata[127:96]);
            end
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input bit [7:0] value, input bit last);
      if (idle_on && $urandom_range(0, 11) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_verdict(value, last);
      bytes_sent++;
   endtask

   // Drop valid, wait for every pending verdict, then let the pipeline drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input cfc_pkg::reg_index_type idx, input bit [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         cfc_pkg::REG_HEAD:    head_cfg = value;
         cfc_pkg::REG_TAIL:    tail_cfg = value;
         cfc_pkg::REG_CONTROL: ctrl_cfg = value;
         default:              ;
      endcase
      @(posedge clock);
   endtask

   task automatic random_payload(output bit [7:0] data [cfc_pkg::DataBytes]);
      foreach (data[i]) data[i] = 8'($urandom_range(0, 255));
   endtask

   function automatic bit [7:0] pick_reg_value();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // faults: [0] head, [1] function, [2] length, [3] check, [4] tail.
   // count below a full frame truncates the buffer; above it pads with noise.
   task automatic send_frame(input bit [7:0] data [cfc_pkg::DataBytes],
                             input bit [4:0] faults, input int count);
      bit [7:0] frm [$];
      bit [7:0] sum;
      sum = head_cfg + ctrl_cfg;
      foreach (data[i]) sum += data[i];
      frm.push_back(head_cfg);
      frm.push_back(ctrl_cfg);
      frm.push_back(cfc_pkg::LenValue);
      foreach (data[i]) frm.push_back(data[i]);
      frm.push_back(~sum);
      frm.push_back(tail_cfg);
      if (faults[0]) frm[0] ^= 8'($urandom_range(1, 255));
      if (faults[1]) frm[1] ^= 8'($urandom_range(1, 255));
      if (faults[2]) frm[2] ^= 8'($urandom_range(1, 255));
      if (faults[3]) frm[cfc_pkg::DataStart + cfc_pkg::DataBytes] ^= 8'($urandom_range(1, 255));
      if (faults[4]) frm[cfc_pkg::FrameBytes - 1] ^= 8'($urandom_range(1, 255));
      while (frm.size() < count) frm.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < count; i++) send_byte(frm[i], i == count - 1);
   endtask

   task automatic test_after_reset();
      bit [7:0] data [cfc_pkg::DataBytes];
      data = '{default: 8'h00};
      send_frame(data, 5'b0, cfc_pkg::FrameBytes);
      send_byte(8'h00, 1'b1);
      settle();
   endtask

   task automatic test_register_extremes();
      bit [7:0] data [cfc_pkg::DataBytes];
      csr_write(cfc_pkg::REG_HEAD, 8'hFF);
      csr_write(cfc_pkg::REG_TAIL, 8'hFF);
      csr_write(cfc_pkg::REG_CONTROL, 8'hFF);
      data = '{default: 8'hFF};
      send_frame(data, 5'b0, cfc_pkg::FrameBytes);
      settle();
      csr_write(cfc_pkg::REG_HEAD, 8'h00);
      csr_write(cfc_pkg::REG_TAIL, 8'hFF);
      csr_write(cfc_pkg::REG_CONTROL, 8'h00);
      foreach (data[i]) data[i] = i[0] ? 8'hAA : 8'h55;
      send_frame(data, 5'b0, cfc_pkg::FrameBytes);
      settle();
      csr_write(cfc_pkg::REG_HEAD, 8'hA5);
      csr_write(cfc_pkg::REG_TAIL, 8'h5A);
      csr_write(cfc_pkg::REG_CONTROL, 8'h3C);
      random_payload(data);
      send_frame(data, 5'b0, cfc_pkg::FrameBytes);
      settle();
   endtask

   task automatic test_each_fault();
      bit [7:0] data [cfc_pkg::DataBytes];
      for (int f = 0; f < 5; f++) begin
         random_payload(data);
         send_frame(data, 5'b1 << f, cfc_pkg::FrameBytes);
      end
      random_payload(data);
      send_frame(data, 5'b0, cfc_pkg::FrameBytes - 1);
      settle();
   endtask

   task automatic test_fault_priority();
      bit [7:0] data [cfc_pkg::DataBytes];
      random_payload(data);
      send_frame(data, 5'b11111, cfc_pkg::FrameBytes);
      send_frame(data, 5'b11110, cfc_pkg::FrameBytes);
      send_frame(data, 5'b01110, cfc_pkg::FrameBytes);
      send_frame(data, 5'b01100, cfc_pkg::FrameBytes);
      send_frame(data, 5'b11111, 3);
      settle();
   endtask

   task automatic test_overlong_buffer();
      bit [7:0] data [cfc_pkg::DataBytes];
      random_payload(data);
      send_frame(data, 5'b0, cfc_pkg::FrameBytes + 1);
      send_frame(data, 5'b0, cfc_pkg::FrameBytes + 9);
      send_frame(data, 5'b10000, cfc_pkg::FrameBytes + 4);
      settle();
   endtask

   // Head and function are judged on arrival, the tail only at buffer end.
   task automatic test_midframe_register_write();
      bit [7:0] data [cfc_pkg::DataBytes];
      bit [7:0] sum;
      csr_write(cfc_pkg::REG_HEAD, 8'h11);
      csr_write(cfc_pkg::REG_CONTROL, 8'h22);
      csr_write(cfc_pkg::REG_TAIL, 8'h33);
      random_payload(data);
      sum = 8'h11 + 8'h22;
      foreach (data[i]) sum += data[i];
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(cfc_pkg::LenValue, 1'b0);
      settle();
      csr_write(cfc_pkg::REG_HEAD, 8'hEE);
      csr_write(cfc_pkg::REG_CONTROL, 8'hDD);
      csr_write(cfc_pkg::REG_TAIL, 8'hCC);
      foreach (data[i]) send_byte(data[i], 1'b0);
      send_byte(~sum, 1'b0);
      send_byte(8'hCC, 1'b1);
      settle();
      send_frame(data, 5'b0, cfc_pkg::FrameBytes);
      settle();
   endtask

   // Hold the receiver off while whole frames keep arriving, so the input stalls.
   task automatic test_output_backpressure();
      bit [7:0] data [cfc_pkg::DataBytes];
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (5) begin
         random_payload(data);
         send_frame(data, 5'b0, cfc_pkg::FrameBytes);
      end
      settle();
   endtask

   task automatic test_random_traffic();
      bit [7:0] data [cfc_pkg::DataBytes];
      bit [4:0] faults;
      int       kind, count, frames, first_byte, n;
      frames = 0;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < RandomBytes) begin
         if (frames % 12 == 0) begin
            settle();
            csr_write(cfc_pkg::REG_HEAD, pick_reg_value());
            csr_write(cfc_pkg::REG_TAIL, pick_reg_value());
            csr_write(cfc_pkg::REG_CONTROL, pick_reg_value());
         end
         if (bytes_sent - first_byte > RandomBytes - 220) idle_on = 1'b0;
         kind = $urandom_range(0, 99);
         faults = 5'b0;
         count = cfc_pkg::FrameBytes;
         if (kind < 30) faults = 5'b1 << $urandom_range(0, 4);
         else if (kind < 42) faults = 5'($urandom_range(1, 31));
         else if (kind < 50) count = $urandom_range(1, cfc_pkg::FrameBytes - 1);
         else if (kind < 57) count = $urandom_range(cfc_pkg::FrameBytes + 1,
                                                    cfc_pkg::FrameBytes + 10);
         if (kind >= 94) begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
         end else begin
            random_payload(data);
            send_frame(data, faults, count);
         end
         frames++;
      end
      settle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_register_extremes();
      test_each_fault();
      test_fault_priority();
      test_overlong_buffer();
      test_midframe_register_write();
      test_output_backpressure();
      test_random_traffic();
      if (mismatches == 0) begin
         $display("control_frame_checker verification clean");
      end else begin
         $display("control_frame_checker verification failed");
      end
      $finish;
   end

endmodule
